>>> rtl/pas_pkg.sv
package pas_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);

    // Field widths of the ports
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 3;
    localparam int OSLOT_W  = 6;
    localparam int ID_W     = 16;
    localparam int CODE_W   = 32;
    localparam int PRIO_W   = 8;
    localparam int WAIT_W   = 16;
    localparam int LIFE_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Lifecycle codes
    localparam logic [LIFE_W-1:0] LS_UNUSED   = 3'd0;
    localparam logic [LIFE_W-1:0] LS_RUNNABLE = 3'd3;
    localparam logic [LIFE_W-1:0] LS_RUNNING  = 3'd4;
    localparam logic [LIFE_W-1:0] LS_ZOMBIE   = 3'd5;

    // Event codes
    localparam logic [MODE_W-1:0] MD_CREATE   = 3'd0;
    localparam logic [MODE_W-1:0] MD_SCHEDULE = 3'd1;
    localparam logic [MODE_W-1:0] MD_YIELD    = 3'd2;
    localparam logic [MODE_W-1:0] MD_EXIT     = 3'd3;
    localparam logic [MODE_W-1:0] MD_AGING    = 3'd4;
    localparam logic [MODE_W-1:0] MD_REAP     = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL          = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE_RUNNABLE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_CURRENT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_CHILDREN   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE_EXITED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BUSY          = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PRIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRIO     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGING_THR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_STEP    = 2'd3;

    localparam logic [PRIO_W-1:0] RST_DEFAULT_PRIO = 8'd10;
    localparam logic [PRIO_W-1:0] RST_MAX_PRIO     = 8'd255;
    localparam logic [WAIT_W-1:0] RST_AGING_THR    = 16'd10;
    localparam logic [PRIO_W-1:0] RST_PRIO_STEP    = 8'd1;
    localparam logic [ID_W-1:0]   RST_NEXT_ID      = 16'd1;

    typedef struct packed {
        logic [LIFE_W-1:0] life;
        logic [PRIO_W-1:0] prio;
        logic [WAIT_W-1:0] wait_cnt;
        logic [ID_W-1:0]   ident;
        logic [CODE_W-1:0] code;
    } t_slot;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_slot             data;
    } t_tbl_wr;

    typedef struct packed {
        logic [PRIO_W-1:0] default_prio;
        logic [PRIO_W-1:0] max_prio;
        logic [WAIT_W-1:0] aging_thr;
        logic [PRIO_W-1:0] prio_step;
    } t_cfg;

    // Per-slot verdict of the shared slot unit
    typedef struct packed {
        logic  hit;
        logic  in_use;
        logic  upd;
        t_slot aged;
    } t_alu_res;

endpackage

>>> rtl/pas_table.sv
module pas_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [pas_pkg::SLOT_W-1:0]  i_rd_addr,
    output pas_pkg::t_slot              o_rd,
    input  pas_pkg::t_tbl_wr            i_wr
);
    import pas_pkg::*;

    logic [LIFE_W-1:0] r_life [TABLE_SLOTS];
    logic [PRIO_W-1:0] r_prio [TABLE_SLOTS];
    logic [WAIT_W-1:0] r_wait [TABLE_SLOTS];
    logic [ID_W-1:0]   r_id   [TABLE_SLOTS];
    logic [CODE_W-1:0] r_code [TABLE_SLOTS];

    // Only the lifecycle field is reset; the other fields are written by any table write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_life[i] <= LS_UNUSED;
            end
        end else if (i_wr.en) begin
            r_life[i_wr.addr] <= i_wr.data.life;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_prio[i_wr.addr] <= i_wr.data.prio;
            r_wait[i_wr.addr] <= i_wr.data.wait_cnt;
            r_id[i_wr.addr]   <= i_wr.data.ident;
            r_code[i_wr.addr] <= i_wr.data.code;
        end
    end

    always_comb begin
        o_rd.life     = r_life[i_rd_addr];
        o_rd.prio     = r_prio[i_rd_addr];
        o_rd.wait_cnt = r_wait[i_rd_addr];
        o_rd.ident    = r_id[i_rd_addr];
        o_rd.code     = r_code[i_rd_addr];
    end

endmodule

>>> rtl/pas_slot_alu.sv
module pas_slot_alu (
    input  logic [pas_pkg::MODE_W-1:0]  i_mode,
    input  logic [pas_pkg::SLOT_W-1:0]  i_idx,
    input  logic [pas_pkg::SLOT_W-1:0]  i_cur_slot,
    input  pas_pkg::t_slot              i_slot,
    input  logic                        i_found,
    input  logic [pas_pkg::PRIO_W-1:0]  i_best_prio,
    input  logic [pas_pkg::WAIT_W-1:0]  i_best_wait,
    input  pas_pkg::t_cfg               i_cfg,
    output pas_pkg::t_alu_res           o_res
);
    import pas_pkg::*;

    logic [WAIT_W-1:0] w_inc;
    logic              w_boost;
    logic [PRIO_W:0]   w_psum;
    logic              w_better;

    // Aging: saturating tick, then boost clamped at the ceiling.
    assign w_inc   = i_slot.wait_cnt + WAIT_W'(i_slot.wait_cnt != '1);
    assign w_boost = (w_inc >= i_cfg.aging_thr) && (i_slot.prio < i_cfg.max_prio);
    assign w_psum  = {1'b0, i_slot.prio} + {1'b0, i_cfg.prio_step};

    assign w_better = !i_found || (i_slot.prio > i_best_prio) ||
                      ((i_slot.prio == i_best_prio) && (i_slot.wait_cnt > i_best_wait));

    always_comb begin
        o_res        = '0;
        o_res.in_use = (i_slot.life != LS_UNUSED);
        o_res.aged   = i_slot;
        if (w_boost) begin
            o_res.aged.prio     = (w_psum > {1'b0, i_cfg.max_prio}) ?
                                  i_cfg.max_prio : w_psum[PRIO_W-1:0];
            o_res.aged.wait_cnt = '0;
        end else begin
            o_res.aged.wait_cnt = w_inc;
        end
        unique case (i_mode)
            MD_CREATE:   o_res.hit = (i_slot.life == LS_UNUSED) && !i_found;
            MD_SCHEDULE: o_res.hit = (i_slot.life == LS_RUNNABLE) && w_better;
            MD_YIELD:    o_res.hit = (i_idx == i_cur_slot);
            MD_EXIT:     o_res.hit = (i_idx == i_cur_slot);
            MD_AGING:    o_res.upd = (i_slot.life == LS_RUNNABLE);
            MD_REAP:     o_res.hit = (i_slot.life == LS_ZOMBIE) && !i_found;
            default:     o_res.hit = 1'b0;
        endcase
    end

endmodule

>>> rtl/pas_ctrl.sv
module pas_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pas_pkg::MODE_W-1:0]    i_mode,
    input  logic [pas_pkg::CODE_W-1:0]    i_exit_code,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pas_pkg::STATUS_W-1:0]  o_status,
    output logic [pas_pkg::OSLOT_W-1:0]   o_slot,
    output logic [pas_pkg::ID_W-1:0]      o_task_id,
    output logic [pas_pkg::CODE_W-1:0]    o_reaped_code,
    input  pas_pkg::t_cfg                 i_cfg,
    output logic [pas_pkg::SLOT_W-1:0]    o_rd_addr,
    input  pas_pkg::t_slot                i_rd,
    output pas_pkg::t_tbl_wr              o_wr
);
    import pas_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_SLOTS - 1);

    logic [1:0]          r_state,     n_state;
    logic [MODE_W-1:0]   r_mode,      n_mode;
    logic [CODE_W-1:0]   r_code,      n_code;
    logic [SLOT_W-1:0]   r_idx,       n_idx;
    logic                r_found,     n_found;
    logic                r_kids,      n_kids;
    logic [SLOT_W-1:0]   r_best,      n_best;
    t_slot               r_best_slot, n_best_slot;
    logic                r_cur_valid, n_cur_valid;
    logic [SLOT_W-1:0]   r_cur_slot,  n_cur_slot;
    logic [ID_W-1:0]     r_next_id,   n_next_id;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status,    n_status;
    logic [OSLOT_W-1:0]  r_oslot,     n_oslot;
    logic [ID_W-1:0]     r_oid,       n_oid;
    logic [CODE_W-1:0]   r_ocode,     n_ocode;

    t_alu_res w_alu;

    pas_slot_alu u_alu (
        .i_mode      (r_mode),
        .i_idx       (r_idx),
        .i_cur_slot  (r_cur_slot),
        .i_slot      (i_rd),
        .i_found     (r_found),
        .i_best_prio (r_best_slot.prio),
        .i_best_wait (r_best_slot.wait_cnt),
        .i_cfg       (i_cfg),
        .o_res       (w_alu)
    );

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_rd_addr     = r_idx;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_slot        = r_oslot;
    assign o_task_id     = r_oid;
    assign o_reaped_code = r_ocode;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_code      = r_code;
        n_idx       = r_idx;
        n_found     = r_found;
        n_kids      = r_kids;
        n_best      = r_best;
        n_best_slot = r_best_slot;
        n_cur_valid = r_cur_valid;
        n_cur_slot  = r_cur_slot;
        n_next_id   = r_next_id;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_oslot     = r_oslot;
        n_oid       = r_oid;
        n_ocode     = r_ocode;
        o_wr        = '0;
        o_wr.addr   = r_idx;
        o_wr.data   = w_alu.aged;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_mode;
                    n_code  = i_exit_code;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_kids  = 1'b0;
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (w_alu.hit) begin
                    n_found     = 1'b1;
                    n_best      = r_idx;
                    n_best_slot = i_rd;
                end
                if (w_alu.in_use) begin
                    n_kids = 1'b1;
                end
                o_wr.en = w_alu.upd;
                if (r_idx == LAST_IDX) begin
                    n_state = S_WRITE;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_WRITE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_oslot     = '0;
                    n_oid       = '0;
                    n_ocode     = '0;
                    o_wr.addr   = r_best;
                    o_wr.data   = r_best_slot;
                    n_state     = S_IDLE;
                    unique case (r_mode) inside
                        MD_CREATE: begin
                            if (r_found) begin
                                o_wr.en            = 1'b1;
                                o_wr.data.life     = LS_RUNNABLE;
                                o_wr.data.prio     = i_cfg.default_prio;
                                o_wr.data.wait_cnt = '0;
                                o_wr.data.ident    = r_next_id;
                                o_wr.data.code     = '0;
                                n_oslot            = OSLOT_W'(r_best);
                                n_oid              = r_next_id;
                                n_next_id          = r_next_id + ID_W'(1);
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        MD_SCHEDULE: begin
                            if (r_cur_valid) begin
                                n_status = ST_BUSY;
                            end else if (r_found) begin
                                o_wr.en            = 1'b1;
                                o_wr.data.life     = LS_RUNNING;
                                o_wr.data.wait_cnt = '0;
                                n_cur_valid        = 1'b1;
                                n_cur_slot         = r_best;
                                n_oslot            = OSLOT_W'(r_best);
                                n_oid              = r_best_slot.ident;
                            end else begin
                                n_status = ST_NONE_RUNNABLE;
                            end
                        end
                        MD_YIELD, MD_EXIT: begin
                            if (r_cur_valid) begin
                                o_wr.en = 1'b1;
                                if (r_mode == MD_EXIT) begin
                                    o_wr.data.life = LS_ZOMBIE;
                                    o_wr.data.code = r_code;
                                end else begin
                                    o_wr.data.life = LS_RUNNABLE;
                                end
                                n_cur_valid = 1'b0;
                                n_oslot     = OSLOT_W'(r_best);
                                n_oid       = r_best_slot.ident;
                            end else begin
                                n_status = ST_NO_CURRENT;
                            end
                        end
                        MD_REAP: begin
                            if (r_found) begin
                                o_wr.en         = 1'b1;
                                o_wr.data.life  = LS_UNUSED;
                                o_wr.data.ident = '0;
                                o_wr.data.code  = '0;
                                n_oslot         = OSLOT_W'(r_best);
                                n_oid           = r_best_slot.ident;
                                n_ocode         = r_best_slot.code;
                            end else begin
                                n_status = r_kids ? ST_NONE_EXITED : ST_NO_CHILDREN;
                            end
                        end
                        default: n_status = ST_OK;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_valid <= 1'b0;
            r_cur_slot  <= '0;
            r_next_id   <= RST_NEXT_ID;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_kids      <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_cur_valid <= n_cur_valid;
            r_cur_slot  <= n_cur_slot;
            r_next_id   <= n_next_id;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_kids      <= n_kids;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_code      <= n_code;
        r_best      <= n_best;
        r_best_slot <= n_best_slot;
        r_status    <= n_status;
        r_oslot     <= n_oslot;
        r_oid       <= n_oid;
        r_ocode     <= n_ocode;
    end

    a_accept_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SWEEP && r_idx == '0))
        else $error("accepted word did not start a sweep at slot zero");

    a_sweep_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_idx != LAST_IDX) |=>
        (r_state == S_SWEEP && r_idx == $past(r_idx) + SLOT_W'(1)))
        else $error("sweep index skipped or stalled");

    a_sweep_write_aging: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && o_wr.en) |-> (r_mode == MD_AGING))
        else $error("table written during a non-aging sweep");

    a_current_from_schedule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_cur_valid) |-> ($past(r_mode) == MD_SCHEDULE && $past(r_state) == S_WRITE))
        else $error("current task set outside a schedule write-back");

endmodule

>>> rtl/priority_aging_process_scheduler_unit.sv
// Flow: an accepted word runs a sweep over every slot of the table, then a write-back state
//   writes any chosen slot and loads the output register once the previous result is taken.
// Words are taken only while idle, one event at a time, as the single table read port
//   is walked once per event by the slot unit; a new word is taken while a result waits.
// Reset (synchronous, active low): all slots unused, no current task, next id one,
//   configuration registers to their defaults, output empty.
module priority_aging_process_scheduler_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // event channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [pas_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [pas_pkg::CODE_W-1:0] i_exit_code,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pas_pkg::STATUS_W-1:0]      o_status,
    output logic [pas_pkg::OSLOT_W-1:0]       o_slot,
    output logic [pas_pkg::ID_W-1:0]          o_task_id,
    output logic signed [pas_pkg::CODE_W-1:0] o_reaped_code,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pas_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pas_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pas_pkg::*;

    // Configuration registers; always writable, and the block reads them live, also during an event.
    t_cfg r_cfg, n_cfg;

    logic [SLOT_W-1:0] w_rd_addr;
    t_slot             w_rd;
    t_tbl_wr           w_wr;
    logic [CODE_W-1:0] w_ocode;

    assign o_cfg_ready = 1'b1;

    // Decode a configuration word; narrow registers take the low bits.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEFAULT_PRIO: n_cfg.default_prio = i_cfg_data[PRIO_W-1:0];
                CFG_MAX_PRIO:     n_cfg.max_prio     = i_cfg_data[PRIO_W-1:0];
                CFG_AGING_THR:    n_cfg.aging_thr    = i_cfg_data[WAIT_W-1:0];
                CFG_PRIO_STEP:    n_cfg.prio_step    = i_cfg_data[PRIO_W-1:0];
                default:          n_cfg              = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_prio <= RST_DEFAULT_PRIO;
            r_cfg.max_prio     <= RST_MAX_PRIO;
            r_cfg.aging_thr    <= RST_AGING_THR;
            r_cfg.prio_step    <= RST_PRIO_STEP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Task table: one read port walked by the sweep, one write port.
    pas_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .o_rd      (w_rd),
        .i_wr      (w_wr)
    );

    // Sequencer: latch the event, sweep every slot through the shared slot unit (aging
    // writes during the sweep), then write back any chosen slot and load the output register.
    pas_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_exit_code   (i_exit_code),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_task_id     (o_task_id),
        .o_reaped_code (w_ocode),
        .i_cfg         (r_cfg),
        .o_rd_addr     (w_rd_addr),
        .i_rd          (w_rd),
        .o_wr          (w_wr)
    );

    assign o_reaped_code = w_ocode;

endmodule

>>> test/priority_aging_process_scheduler_unit_tb.sv
module priority_aging_process_scheduler_unit_tb;
    import pas_pkg::*;

    // Event codes that the block treats as no-ops
    localparam logic [MODE_W-1:0] MD_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MD_SPARE_HI = 3'd7;

    // One table sweep plus write-back per event
    localparam int LATENCY  = TABLE_SLOTS + 2;
    localparam int IDLE_PCT = 13;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OSLOT_W-1:0]  slot;
        logic [ID_W-1:0]     task_id;
        logic [CODE_W-1:0]   reaped_code;
    } t_sched_result;

    // One row of the opening sequence; typed rows carry a hand-written answer
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CODE_W-1:0] code;
        logic              typed;
        t_sched_result     want;
    } t_opening_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [MODE_W-1:0]          i_mode = '0;
    logic signed [CODE_W-1:0]   i_exit_code = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [STATUS_W-1:0]        o_status;
    logic [OSLOT_W-1:0]         o_slot;
    logic [ID_W-1:0]            o_task_id;
    logic signed [CODE_W-1:0]   o_reaped_code;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    priority_aging_process_scheduler_unit DUT (.*);

    // ------------------------------------------------------------------
    // Shadow copy of the task table and its registers
    // ------------------------------------------------------------------
    logic [PRIO_W-1:0] cfg_default_prio;
    logic [PRIO_W-1:0] cfg_max_prio;
    logic [WAIT_W-1:0] cfg_aging_thr;
    logic [PRIO_W-1:0] cfg_prio_step;

    logic [LIFE_W-1:0] life_tbl [TABLE_SLOTS];
    logic [PRIO_W-1:0] prio_tbl [TABLE_SLOTS];
    logic [WAIT_W-1:0] wait_tbl [TABLE_SLOTS];
    logic [ID_W-1:0]   id_tbl   [TABLE_SLOTS];
    logic [CODE_W-1:0] code_tbl [TABLE_SLOTS];
    logic [ID_W-1:0]   next_id;
    logic              cur_valid;
    int                cur_slot;

    // Expected results, oldest first
    t_sched_result expected_results [$];
    t_opening_row  opening_rows [$];

    // Relative weight of each event code in the random part, indexed by code
    int unsigned mix [8];
    bit          steady = 1'b0;

    int n_errors  = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int status_seen [8];

    // Put the shadow table into its post-reset state
    function automatic void clear_task_table();
        cfg_default_prio = RST_DEFAULT_PRIO;
        cfg_max_prio     = RST_MAX_PRIO;
        cfg_aging_thr    = RST_AGING_THR;
        cfg_prio_step    = RST_PRIO_STEP;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            life_tbl[i] = LS_UNUSED;
            prio_tbl[i] = '0;
            wait_tbl[i] = '0;
            id_tbl[i]   = '0;
            code_tbl[i] = '0;
        end
        next_id   = RST_NEXT_ID;
        cur_valid = 1'b0;
        cur_slot  = 0;
        for (int s = 0; s < 8; s++) status_seen[s] = 0;
    endfunction

    function automatic void set_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DEFAULT_PRIO: cfg_default_prio = data[PRIO_W-1:0];
            CFG_MAX_PRIO:     cfg_max_prio     = data[PRIO_W-1:0];
            CFG_AGING_THR:    cfg_aging_thr    = data[WAIT_W-1:0];
            CFG_PRIO_STEP:    cfg_prio_step    = data[PRIO_W-1:0];
            default: ;
        endcase
    endfunction

    // Apply one event to the shadow table and return the word it answers with
    function automatic t_sched_result advance_table(logic [MODE_W-1:0] mode,
                                                    logic [CODE_W-1:0] code);
        t_sched_result r;
        int            best;
        int            boosted;
        bit            kids;
        r    = '0;
        best = -1;
        kids = 1'b0;
        case (mode)
            MD_CREATE: begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                    if (best < 0 && life_tbl[i] == LS_UNUSED) best = i;
                if (best < 0) begin
                    r.status = ST_FULL;
                end else begin
                    id_tbl[best]   = next_id;
                    next_id        = next_id + 1'b1;
                    prio_tbl[best] = cfg_default_prio;
                    wait_tbl[best] = '0;
                    code_tbl[best] = '0;
                    life_tbl[best] = LS_RUNNABLE;
                    r.status  = ST_OK;
                    r.slot    = OSLOT_W'(best);
                    r.task_id = id_tbl[best];
                end
            end
            MD_SCHEDULE: begin
                if (cur_valid) begin
                    r.status = ST_BUSY;
                end else begin
                    // highest priority, then longest wait, then lowest index
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        if (life_tbl[i] == LS_RUNNABLE &&
                            (best < 0 || prio_tbl[i] > prio_tbl[best] ||
                             (prio_tbl[i] == prio_tbl[best] &&
                              wait_tbl[i] > wait_tbl[best])))
                            best = i;
                    end
                    if (best < 0) begin
                        r.status = ST_NONE_RUNNABLE;
                    end else begin
                        life_tbl[best] = LS_RUNNING;
                        wait_tbl[best] = '0;
                        cur_valid = 1'b1;
                        cur_slot  = best;
                        r.status  = ST_OK;
                        r.slot    = OSLOT_W'(best);
                        r.task_id = id_tbl[best];
                    end
                end
            end
            MD_YIELD, MD_EXIT: begin
                if (!cur_valid) begin
                    r.status = ST_NO_CURRENT;
                end else begin
                    if (mode == MD_EXIT) begin
                        code_tbl[cur_slot] = code;
                        life_tbl[cur_slot] = LS_ZOMBIE;
                    end else begin
                        life_tbl[cur_slot] = LS_RUNNABLE;
                    end
                    cur_valid = 1'b0;
                    r.status  = ST_OK;
                    r.slot    = OSLOT_W'(cur_slot);
                    r.task_id = id_tbl[cur_slot];
                end
            end
            MD_AGING: begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (life_tbl[i] == LS_RUNNABLE) begin
                        if (wait_tbl[i] != {WAIT_W{1'b1}}) wait_tbl[i] = wait_tbl[i] + 1'b1;
                        if (wait_tbl[i] >= cfg_aging_thr && prio_tbl[i] < cfg_max_prio) begin
                            boosted = int'(prio_tbl[i]) + int'(cfg_prio_step);
                            if (boosted > int'(cfg_max_prio)) boosted = cfg_max_prio;
                            prio_tbl[i] = PRIO_W'(boosted);
                            wait_tbl[i] = '0;
                        end
                    end
                end
                r.status = ST_OK;
            end
            MD_REAP: begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (best < 0) begin
                        if (life_tbl[i] == LS_ZOMBIE) best = i;
                        else if (life_tbl[i] != LS_UNUSED) kids = 1'b1;
                    end
                end
                if (best < 0) begin
                    r.status = kids ? ST_NONE_EXITED : ST_NO_CHILDREN;
                end else begin
                    r.status      = ST_OK;
                    r.slot        = OSLOT_W'(best);
                    r.task_id     = id_tbl[best];
                    r.reaped_code = code_tbl[best];
                    life_tbl[best] = LS_UNUSED;
                    id_tbl[best]   = '0;
                    code_tbl[best] = '0;
                end
            end
            default: r.status = ST_OK;
        endcase
        return r;
    endfunction

    function automatic void add_row(logic [MODE_W-1:0] mode, logic [CODE_W-1:0] code,
                                    logic typed, logic [STATUS_W-1:0] st,
                                    logic [OSLOT_W-1:0] sl, logic [ID_W-1:0] id,
                                    logic [CODE_W-1:0] rc);
        t_opening_row row;
        row.mode = mode;
        row.code = code;
        row.typed = typed;
        row.want = '{st, sl, id, rc};
        opening_rows.push_back(row);
    endfunction

    // Pick an event code by the weights of the current phase
    function automatic logic [MODE_W-1:0] pick_mode();
        int unsigned total;
        int unsigned r;
        logic [MODE_W-1:0] m;
        bit done;
        total = 0;
        done  = 1'b0;
        m     = MD_CREATE;
        for (int k = 0; k < 8; k++) total += mix[k];
        r = $urandom_range(total - 1);
        for (int k = 0; k < 8; k++) begin
            if (!done) begin
                if (r < mix[k]) begin
                    m = MODE_W'(k);
                    done = 1'b1;
                end else begin
                    r -= mix[k];
                end
            end
        end
        return m;
    endfunction

    // Lean on the sign bit and all-ones patterns, otherwise any value
    function automatic logic [CODE_W-1:0] pick_code();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one event word; hold it until taken, then record what it must produce.
    // Valid is only dropped inside an idle gap, so it never sees two updates in one step.
    task automatic send_event(input logic [MODE_W-1:0] mode, input logic [CODE_W-1:0] code,
                              input logic typed, input t_sched_result want);
        t_sched_result predicted;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_exit_code <= code;
        do @(posedge i_clk); while (!o_in_ready);
        // Accepted at this edge: advance the shadow table in lock step
        predicted = advance_table(mode, code);
        expected_results.push_back(typed ? want : predicted);
        n_sent++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        set_register(idx, data);
    endtask

    // Write all four registers back to back, then drop the channel
    task automatic load_settings(input logic [PRIO_W-1:0] dflt, input logic [PRIO_W-1:0] ceil,
                                 input logic [WAIT_W-1:0] thr, input logic [PRIO_W-1:0] boost);
        write_register(CFG_DEFAULT_PRIO, CFG_DATA_W'(dflt));
        write_register(CFG_MAX_PRIO, CFG_DATA_W'(ceil));
        write_register(CFG_AGING_THR, thr);
        write_register(CFG_PRIO_STEP, CFG_DATA_W'(boost));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering words and wait until every expected word has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic run_phase(input int count);
        repeat (count) send_event(pick_mode(), pick_code(), 1'b0, '0);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_sched_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with no event pending: status %0d slot %0d",
                       o_status, o_slot);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                status_seen[want.status]++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    n_errors++;
                end
                if (o_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, o_slot);
                    n_errors++;
                end
                if (o_task_id !== want.task_id) begin
                    $error("task_id: expected %0d, got %0d", want.task_id, o_task_id);
                    n_errors++;
                end
                if (o_reaped_code !== want.reaped_code) begin
                    $error("reaped_code: expected %0d, got %0d",
                           $signed(want.reaped_code), o_reaped_code);
                    n_errors++;
                end
            end
        end
        // Stall at random, except in the steady stretch
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Clock, limit and main sequence
    // ------------------------------------------------------------------
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        clear_task_table();

        // Opening sequence: empty table, one task through its whole life,
        // spare codes, then a short mix left to the shadow table
        add_row(MD_REAP,     '0,           1, ST_NO_CHILDREN,   0, 0, '0);
        add_row(MD_YIELD,    '0,           1, ST_NO_CURRENT,    0, 0, '0);
        add_row(MD_EXIT,     32'h7FFF_FFFF, 1, ST_NO_CURRENT,   0, 0, '0);
        add_row(MD_SCHEDULE, '0,           1, ST_NONE_RUNNABLE, 0, 0, '0);
        add_row(MD_AGING,    32'hFFFF_FFFF, 1, ST_OK,           0, 0, '0);
        add_row(MD_CREATE,   '0,           1, ST_OK,            0, 1, '0);
        add_row(MD_REAP,     '0,           1, ST_NONE_EXITED,   0, 0, '0);
        add_row(MD_SCHEDULE, '0,           1, ST_OK,            0, 1, '0);
        add_row(MD_SCHEDULE, '0,           1, ST_BUSY,          0, 0, '0);
        // a running task still counts as a child
        add_row(MD_REAP,     '0,           1, ST_NONE_EXITED,   0, 0, '0);
        add_row(MD_EXIT,     32'h8000_0000, 1, ST_OK,           0, 1, '0);
        add_row(MD_REAP,     '0,           1, ST_OK,            0, 1, 32'h8000_0000);
        add_row(MD_REAP,     '0,           1, ST_NO_CHILDREN,   0, 0, '0);
        add_row(MD_SPARE_LO, 32'h7FFF_FFFF, 1, ST_OK,           0, 0, '0);
        add_row(MD_SPARE_HI, 32'h8000_0000, 1, ST_OK,           0, 0, '0);
        add_row(MD_CREATE,   '0,           0, ST_OK,            0, 0, '0);
        add_row(MD_CREATE,   '0,           0, ST_OK,            0, 0, '0);
        // equal priority and wait: lower index wins
        add_row(MD_SCHEDULE, '0,           0, ST_OK,            0, 0, '0);
        add_row(MD_YIELD,    '0,           0, ST_OK,            0, 0, '0);
        add_row(MD_AGING,    '0,           0, ST_OK,            0, 0, '0);
        add_row(MD_SCHEDULE, '0,           0, ST_OK,            0, 0, '0);
        add_row(MD_EXIT,     32'hFFFF_FFFF, 0, ST_OK,           0, 0, '0);
        add_row(MD_EXIT,     '0,           1, ST_NO_CURRENT,    0, 0, '0);
        add_row(MD_REAP,     '0,           0, ST_OK,            0, 0, '0);

        // Hold reset, then release
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_rows[n])
            send_event(opening_rows[n].mode, opening_rows[n].code,
                       opening_rows[n].typed, opening_rows[n].want);
        drain();

        // Reset settings, balanced mix
        mix = '{20, 20, 15, 15, 20, 8, 1, 1};
        run_phase(200);

        // Lowest default, full ceiling, boost on every tick by the largest step:
        // create-heavy so the table fills up
        load_settings(8'd0, 8'd255, 16'd1, 8'd255);
        mix = '{45, 15, 8, 10, 12, 5, 2, 3};
        run_phase(230);

        // Ceiling at zero and the longest threshold: no boost can happen
        load_settings(8'd255, 8'd0, 16'hFFFF, 8'd0);
        mix = '{15, 25, 15, 15, 20, 8, 1, 1};
        run_phase(200);

        // Middle settings with both sides streaming without gaps
        load_settings(8'd128, 8'd200, 16'd3, 8'd7);
        steady = 1'b1;
        mix = '{20, 20, 15, 15, 20, 8, 1, 1};
        run_phase(230);
        steady = 1'b0;

        // Low ceiling and heavy aging: boosts clamp often
        load_settings(8'd5, 8'd40, 16'd2, 8'd16);
        mix = '{15, 15, 15, 10, 35, 8, 1, 1};
        run_phase(230);

        // Random settings, reap-leaning mix
        load_settings(PRIO_W'($urandom_range(255)), PRIO_W'($urandom_range(255)),
                      WAIT_W'($urandom_range(1, 20)), PRIO_W'($urandom_range(255)));
        mix = '{20, 20, 12, 12, 20, 14, 1, 1};
        run_phase(260);

        $display("Ran %0d events through six register settings, %0d result words checked.",
                 n_sent, n_checked);
        $display("Statuses: ok %0d, full %0d, none runnable %0d, no current %0d, ",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NONE_RUNNABLE],
                 status_seen[ST_NO_CURRENT],
                 "no children %0d, none exited %0d, busy %0d",
                 status_seen[ST_NO_CHILDREN], status_seen[ST_NONE_EXITED],
                 status_seen[ST_BUSY]);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/pas_pkg.sv
rtl/pas_table.sv
rtl/pas_slot_alu.sv
rtl/pas_ctrl.sv
rtl/priority_aging_process_scheduler_unit.sv
test/priority_aging_process_scheduler_unit_tb.sv
